### src/laplacian_edge_filter_3x3_assert.svh
`ifndef LAPLACIAN_EDGE_FILTER_3X3_ASSERT_SVH
`define LAPLACIAN_EDGE_FILTER_3X3_ASSERT_SVH

// same-cycle implication
`define LEF_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("laplacian_edge_filter_3x3: same-cycle check failed");

// next-cycle implication
`define LEF_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("laplacian_edge_filter_3x3: next-cycle check failed");

`endif

### src/lef_pkg.sv
package lef_pkg;

   localparam int PIXEL_W           = 8;
   localparam int COORD_W           = 10;
   localparam int FRAME_SIDE_W      = 11;
   localparam int FRAME_SIDE_RESET  = 1024;
   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int RSP_TDATA_W       = 32;
   localparam int NUM_CELLS         = 3;
   localparam int COL_SUM_W         = 10;
   localparam int KERNEL_SUM_W      = 12;

   // register index, decoded from csr_paddr[2]
   localparam logic CSR_FRAME_SIDE = 1'b0;

   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] bot;
   } column_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] upper;
      logic [PIXEL_W-1:0] middle;
   } line_pair_type;

endpackage

### src/lef_cell.sv
module lef_cell
   import lef_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  column_type           col_in,
   output column_type           col_q,
   output logic [COL_SUM_W-1:0] col_sum
);

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_q   = col_ff;
   assign col_sum = COL_SUM_W'(col_ff.top) + COL_SUM_W'(col_ff.mid) + COL_SUM_W'(col_ff.bot);

endmodule

### src/lef_line_store.sv
module lef_line_store
   import lef_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_WIDTH,
   parameter int AW    = $clog2(DEFAULT_MAX_WIDTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output line_pair_type rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  line_pair_type wr_data
);

   line_pair_type mem [DEPTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/laplacian_edge_filter_3x3.sv
// Path: a pixel beat passes through the stage 1 registers and the window cells to the result register.
// Throughput: one pixel beat per cycle unless the skid register is full; the line store read port
//   and the three window cells advance once per beat, and a skid register holds one result when rsp stalls.
// Reset: row and column counters clear, the side register returns to 1024, window cells clear.
//   The line stores are not cleared; stale entries are read only for rows 0 and 1, which emit no result.
module laplacian_edge_filter_3x3
   import lef_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // [7:0] pixel_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] out_pixel, [17:8] out_row, [27:18] out_col
   output logic                   rsp_tlast,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int AW           = $clog2(MAX_WIDTH);
   localparam int CMPW         = (AW + 1 > FRAME_SIDE_W) ? AW + 1 : FRAME_SIDE_W;
   localparam int SIDE_RESET   = (FRAME_SIDE_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_SIDE_RESET;
   localparam int PAD_W        = RSP_TDATA_W - PIXEL_W - 2 * COORD_W;

   // configuration
   logic                    cfg_wr;
   logic [FRAME_SIDE_W-1:0] frame_side_ff;
   logic [AW-1:0]           side_m1_ff;
   logic [AW-1:0]           side_m1_in;
   logic [CMPW-1:0]         wr_size;
   logic [CMPW-1:0]         wr_size_m1;

   // pipeline control
   logic                    en;
   logic                    accept;

   // position counters
   logic [AW-1:0]           row_ff;
   logic [AW-1:0]           col_ff;
   logic [AW-1:0]           row_m1;
   logic [AW-1:0]           col_m1;

   // stage 1: line store read in flight
   logic                    s1_valid_ff;
   logic [PIXEL_W-1:0]      s1_pixel_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;
   logic [COORD_W-1:0]      s1_row_ff;
   logic [COORD_W-1:0]      s1_col_ff;

   // stage 2: window cells hold the full neighborhood
   logic                    s2_valid_ff;
   logic                    s2_emit_ff;
   logic                    s2_last_ff;
   logic [COORD_W-1:0]      s2_row_ff;
   logic [COORD_W-1:0]      s2_col_ff;

   line_pair_type           rd_pair;
   line_pair_type           wr_pair;
   column_type              new_col;
   column_type              cell_in  [NUM_CELLS];
   column_type              cell_q   [NUM_CELLS];
   logic [COL_SUM_W-1:0]    cell_sum [NUM_CELLS];

   logic [KERNEL_SUM_W-1:0] total;
   logic [KERNEL_SUM_W-1:0] center_x9;
   logic [KERNEL_SUM_W:0]   diff;
   logic [PIXEL_W-1:0]      clamped;

   // result and skid registers
   logic                    prod_valid;
   logic                    out_valid_ff;
   logic [PIXEL_W-1:0]      out_pixel_ff;
   logic [COORD_W-1:0]      out_row_ff;
   logic [COORD_W-1:0]      out_col_ff;
   logic                    out_last_ff;
   logic                    skid_valid_ff;
   logic [PIXEL_W-1:0]      skid_pixel_ff;
   logic [COORD_W-1:0]      skid_row_ff;
   logic [COORD_W-1:0]      skid_col_ff;
   logic                    skid_last_ff;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_FRAME_SIDE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_FRAME_SIDE) ? CSR_DATA_W'(frame_side_ff) : '0;

   assign wr_size    = CMPW'(csr_pwdata[FRAME_SIDE_W-1:0]);
   assign wr_size_m1 = wr_size - CMPW'(1);

   always_comb begin
      priority if (wr_size < CMPW'(3)) begin
         side_m1_in = AW'(2);
      end else if (wr_size > CMPW'(MAX_WIDTH)) begin
         side_m1_in = AW'(MAX_WIDTH - 1);
      end else begin
         side_m1_in = wr_size_m1[AW-1:0];
      end
   end

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   assign row_m1 = row_ff - AW'(1);
   assign col_m1 = col_ff - AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_side_ff <= FRAME_SIDE_W'(FRAME_SIDE_RESET);
         side_m1_ff    <= AW'(SIDE_RESET - 1);
         row_ff        <= '0;
         col_ff        <= '0;
      end else if (cfg_wr) begin
         frame_side_ff <= csr_pwdata[FRAME_SIDE_W-1:0];
         side_m1_ff    <= side_m1_in;
         row_ff        <= '0;
         col_ff        <= '0;
      end else if (accept) begin
         if (col_ff == side_m1_ff) begin
            col_ff <= '0;
            row_ff <= (row_ff == side_m1_ff) ? '0 : row_ff + AW'(1);
         end else begin
            col_ff <= col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_tdata;
         s1_addr_ff  <= col_ff;
         s1_emit_ff  <= (row_ff >= AW'(2)) && (col_ff >= AW'(2));
         s1_last_ff  <= (row_ff == side_m1_ff) && (col_ff == side_m1_ff);
         s1_row_ff   <= COORD_W'(row_m1);
         s1_col_ff   <= COORD_W'(col_m1);
      end
      if (en) begin
         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
      end
   end

   assign wr_pair.upper  = rd_pair.middle;
   assign wr_pair.middle = s1_pixel_ff;

   lef_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_pair),
      .wr_en   (en && s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_pair)
   );

   assign new_col.top = rd_pair.upper;
   assign new_col.mid = rd_pair.middle;
   assign new_col.bot = s1_pixel_ff;

   // cell 0 holds the newest column, the last cell the oldest
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_in[i] = new_col;
      end else begin : g_link
         assign cell_in[i] = cell_q[i-1];
      end
      lef_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (en && s1_valid_ff),
         .col_in   (cell_in[i]),
         .col_q    (cell_q[i]),
         .col_sum  (cell_sum[i])
      );
   end

   assign total     = KERNEL_SUM_W'(cell_sum[0]) + KERNEL_SUM_W'(cell_sum[1])
                      + KERNEL_SUM_W'(cell_sum[2]);
   assign center_x9 = (KERNEL_SUM_W'(cell_q[1].mid) << 3) + KERNEL_SUM_W'(cell_q[1].mid);
   assign diff      = {1'b0, center_x9} - {1'b0, total};

   always_comb begin
      priority if (diff[KERNEL_SUM_W]) begin
         clamped = '0;
      end else if (diff[KERNEL_SUM_W-1:PIXEL_W] != '0) begin
         clamped = '1;
      end else begin
         clamped = diff[PIXEL_W-1:0];
      end
   end

   assign prod_valid = en && s2_valid_ff && s2_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_tready || !out_valid_ff) begin
         out_valid_ff  <= skid_valid_ff || prod_valid;
         skid_valid_ff <= 1'b0;
      end else if (prod_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_pixel_ff <= skid_pixel_ff;
            out_row_ff   <= skid_row_ff;
            out_col_ff   <= skid_col_ff;
            out_last_ff  <= skid_last_ff;
         end else begin
            out_pixel_ff <= clamped;
            out_row_ff   <= s2_row_ff;
            out_col_ff   <= s2_col_ff;
            out_last_ff  <= s2_last_ff;
         end
      end else if (prod_valid) begin
         skid_pixel_ff <= clamped;
         skid_row_ff   <= s2_row_ff;
         skid_col_ff   <= s2_col_ff;
         skid_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), out_col_ff, out_row_ff, out_pixel_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

### src/lef_checker.sv
`include "laplacian_edge_filter_3x3_assert.svh"

module lef_checker
   import lef_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   `LEF_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `LEF_ASSERT_IMP(a_interior, rsp_tvalid, rsp_tdata[17:8] != 10'd0 && rsp_tdata[27:18] != 10'd0 && rsp_tdata[31:28] == 4'd0)
   `LEF_ASSERT_IMP(a_last_diag, rsp_tvalid && rsp_tlast, rsp_tdata[17:8] == rsp_tdata[27:18])
   `LEF_ASSERT_IMP(a_stall_cause, !req_tready, $past(rsp_tvalid && !rsp_tready))

endmodule

bind laplacian_edge_filter_3x3 lef_checker u_lef_checker (.*);
